@@ src/fcdma_pkg.sv @@
// shared types, constants and control-word layout for the four-channel dma controller
package fcdma_pkg;

  localparam int NUM_CH = 4;
  localparam int CH_W   = 2;
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 16;
  localparam int REM_W  = 17;
  localparam int KIND_W = 3;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SRC  = 3'd0,
    KIND_DST  = 3'd1,
    KIND_CNT  = 3'd2,
    KIND_CTRL = 3'd3,
    KIND_TICK = 3'd4
  } kind_t;

  // control word bit positions
  localparam int CTL_DST_LSB = 5;
  localparam int CTL_SRC_LSB = 7;
  localparam int CTL_REPEAT  = 9;
  localparam int CTL_WIDE    = 10;
  localparam int CTL_TIM_LSB = 12;
  localparam int CTL_IRQ     = 14;
  localparam int CTL_ENABLE  = 15;

  // pointer control codes
  localparam logic [1:0] AC_INC    = 2'd0;
  localparam logic [1:0] AC_DEC    = 2'd1;
  localparam logic [1:0] AC_FIX    = 2'd2;
  localparam logic [1:0] AC_RELOAD = 2'd3;
  localparam logic [1:0] TIM_IMMED = 2'd0;

  localparam logic [REM_W-1:0]  ZCNT_LAST  = 17'h10000;
  localparam logic [REM_W-1:0]  ZCNT_OTHER = 17'h04000;
  localparam logic [ADDR_W-1:0] STEP_WORD  = 32'd4;
  localparam logic [ADDR_W-1:0] STEP_HALF  = 32'd2;

  typedef struct packed {
    logic              upd;
    logic              sel;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
  } chan_cmd_t;

  typedef struct packed {
    logic              run;
    logic              err;
    logic              en_nxt;
    logic              busy_nxt;
    logic              irq;
    logic              wide;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } chan_sts_t;

endpackage

@@ src/fcdma_chan.sv @@
// one dma channel: register file, working pointers, count and step update
module fcdma_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fcdma_pkg::chan_cmd_t        cmd,
  input  logic                        grant,
  input  logic [fcdma_pkg::REM_W-1:0] zero_cnt,
  output fcdma_pkg::chan_sts_t        sts
);
  import fcdma_pkg::*;

  logic [ADDR_W-1:0] src_latch_r, src_latch_nxt;
  logic [ADDR_W-1:0] dst_latch_r, dst_latch_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ctrl_r, ctrl_nxt;
  logic [ADDR_W-1:0] sptr_r, sptr_nxt;
  logic [ADDR_W-1:0] dptr_r, dptr_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              busy_r, busy_nxt;

  logic [ADDR_W-1:0] step, sptr_step, dptr_step;
  logic [REM_W-1:0]  load_cnt, rem_dec;
  logic [1:0]        dc, sc, tim;
  logic              en, start, irq;

  always_comb begin
    en       = ctrl_r[CTL_ENABLE];
    tim      = ctrl_r[CTL_TIM_LSB +: 2];
    dc       = ctrl_r[CTL_DST_LSB +: 2];
    sc       = ctrl_r[CTL_SRC_LSB +: 2];
    start    = en && !busy_r && (tim == TIM_IMMED);
    step     = ctrl_r[CTL_WIDE] ? STEP_WORD : STEP_HALF;
    load_cnt = (cnt_r != '0) ? {1'b0, cnt_r} : zero_cnt;
    rem_dec  = rem_r - REM_W'(1);

    case (dc) inside
      AC_INC, AC_RELOAD: dptr_step = dptr_r + step;
      AC_DEC:            dptr_step = dptr_r - step;
      default:           dptr_step = dptr_r;
    endcase
    case (sc)
      AC_INC:  sptr_step = sptr_r + step;
      AC_DEC:  sptr_step = sptr_r - step;
      default: sptr_step = sptr_r;
    endcase

    src_latch_nxt = src_latch_r;
    dst_latch_nxt = dst_latch_r;
    cnt_nxt       = cnt_r;
    ctrl_nxt      = ctrl_r;
    sptr_nxt      = sptr_r;
    dptr_nxt      = dptr_r;
    rem_nxt       = rem_r;
    busy_nxt      = busy_r;
    irq           = 1'b0;

    if (cmd.upd) begin
      unique case (cmd.kind)
        KIND_TICK: begin
          busy_nxt = busy_r || start;
          if (grant) begin
            sptr_nxt = sptr_step;
            dptr_nxt = dptr_step;
            rem_nxt  = rem_dec;
            if (rem_dec == '0) begin
              busy_nxt = 1'b0;
              irq      = ctrl_r[CTL_IRQ];
              if (ctrl_r[CTL_REPEAT]) begin
                rem_nxt = load_cnt;
                if (dc == AC_RELOAD) dptr_nxt = dst_latch_r;
              end else begin
                ctrl_nxt[CTL_ENABLE] = 1'b0;
              end
            end
          end
        end
        KIND_SRC: if (cmd.sel) src_latch_nxt = cmd.data;
        KIND_DST: if (cmd.sel) dst_latch_nxt = cmd.data;
        KIND_CNT: if (cmd.sel) cnt_nxt = cmd.data[CNT_W-1:0];
        KIND_CTRL: begin
          if (cmd.sel) begin
            ctrl_nxt = cmd.data[CNT_W-1:0];
            // rising enable latches the working set
            if (!en && cmd.data[CTL_ENABLE]) begin
              sptr_nxt = src_latch_r;
              dptr_nxt = dst_latch_r;
              rem_nxt  = load_cnt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_latch_r <= '0;
      dst_latch_r <= '0;
      cnt_r       <= '0;
      ctrl_r      <= '0;
      sptr_r      <= '0;
      dptr_r      <= '0;
      rem_r       <= '0;
      busy_r      <= 1'b0;
    end else begin
      src_latch_r <= src_latch_nxt;
      dst_latch_r <= dst_latch_nxt;
      cnt_r       <= cnt_nxt;
      ctrl_r      <= ctrl_nxt;
      sptr_r      <= sptr_nxt;
      dptr_r      <= dptr_nxt;
      rem_r       <= rem_nxt;
      busy_r      <= busy_nxt;
    end
  end

  always_comb begin
    sts.run      = busy_r || start;
    sts.err      = en && !busy_r && (tim != TIM_IMMED);
    sts.en_nxt   = ctrl_nxt[CTL_ENABLE];
    sts.busy_nxt = busy_nxt;
    sts.irq      = irq;
    sts.wide     = ctrl_r[CTL_WIDE];
    sts.src      = sptr_r;
    sts.dst      = dptr_r;
  end

endmodule

@@ src/fcdma_arb.sv @@
// fixed priority pick: lowest-numbered running channel wins
module fcdma_arb (
  input  logic [fcdma_pkg::NUM_CH-1:0] req,
  output logic [fcdma_pkg::NUM_CH-1:0] grant,
  output logic [fcdma_pkg::CH_W-1:0]   idx,
  output logic                         any
);
  import fcdma_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (req[i]) idx = CH_W'(i);
    end
    any   = |req;
    grant = any ? (NUM_CH'(1) << idx) : '0;
  end

endmodule

@@ src/four_channel_dma_controller.sv @@
// top level of the four-channel dma controller: request/result registers and channel array
//
// usage:
//   the in_ channel carries one request per item: a register write
//   (source, destination, count or control of in_channel) or a tick.
//   on a tick every enabled idle channel with immediate start timing
//   begins running, and the lowest-numbered running channel issues one
//   halfword or word transfer; the consumer does the copy itself from
//   out_src_addr to out_dst_addr.
//   every request produces exactly one result on the out_ channel.
// pipeline:
//   a request is held in the input register, where the channel state and
//   the result are computed combinationally; the result is then captured in
//   the result register. one request per cycle is accepted while out_ready
//   stays high.
// reset:
//   synchronous, active low; all channel registers clear, all channels idle
//   and both pipeline registers empty.
// stall:
//   while out_ready is low a held result keeps its value; the input register
//   still takes one more request, then in_ready drops until the result drains.
module four_channel_dma_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fcdma_pkg::KIND_W-1:0] in_kind,
  input  logic [fcdma_pkg::CH_W-1:0]   in_channel,
  input  logic [fcdma_pkg::DATA_W-1:0] in_data_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_xfer_valid,
  output logic [fcdma_pkg::CH_W-1:0]   out_xfer_channel,
  output logic [fcdma_pkg::ADDR_W-1:0] out_src_addr,
  output logic [fcdma_pkg::ADDR_W-1:0] out_dst_addr,
  output logic                         out_wide,
  output logic [fcdma_pkg::NUM_CH-1:0] out_irq_bits,
  output logic                         out_start_error,
  output logic                         out_any_enabled,
  output logic                         out_any_running
);
  import fcdma_pkg::*;

  // input register: holds the request being processed
  logic              in_vld_r, in_vld_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [CH_W-1:0]   chan_r;
  logic [DATA_W-1:0] data_r;

  // result register
  logic              out_vld_r, out_vld_nxt;
  logic              xfer_r, wide_r, err_r, en_any_r, run_any_r;
  logic [CH_W-1:0]   xch_r;
  logic [ADDR_W-1:0] src_r, dst_r;
  logic [NUM_CH-1:0] irq_r;

  logic              adv, take, tick, xfer;
  chan_cmd_t         cmd [NUM_CH];
  chan_sts_t         sts [NUM_CH];
  logic [NUM_CH-1:0] run_vec, err_vec, en_vec, busy_vec, irq_vec, grant;
  logic [CH_W-1:0]   gidx;
  logic              gany;

  // the request in the input register moves on when the result slot is free
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign take     = in_valid && in_ready;
  assign tick     = (kind_r == KIND_TICK);

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take)     in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (adv)            out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= in_kind;
      chan_r <= in_channel;
      data_r <= in_data_value;
    end
  end

  // channel array; the last channel treats a zero count as the long count
  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    always_comb begin
      cmd[i].upd  = adv;
      cmd[i].sel  = (chan_r == CH_W'(i));
      cmd[i].kind = kind_r;
      cmd[i].data = data_r;
    end

    fcdma_chan u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd[i]),
      .grant    (grant[i]),
      .zero_cnt ((i == NUM_CH - 1) ? ZCNT_LAST : ZCNT_OTHER),
      .sts      (sts[i])
    );

    assign run_vec[i]  = sts[i].run;
    assign err_vec[i]  = sts[i].err;
    assign en_vec[i]   = sts[i].en_nxt;
    assign busy_vec[i] = sts[i].busy_nxt;
    assign irq_vec[i]  = sts[i].irq;
  end

  // grant is only acted on for ticks; channels gate it with the request kind
  fcdma_arb u_arb (
    .req   (run_vec),
    .grant (grant),
    .idx   (gidx),
    .any   (gany)
  );

  assign xfer = tick && gany;

  // result capture; transfer fields read zero when nothing moved
  always_ff @(posedge clk) begin
    if (adv) begin
      xfer_r    <= xfer;
      xch_r     <= xfer ? gidx : '0;
      src_r     <= xfer ? sts[gidx].src : '0;
      dst_r     <= xfer ? sts[gidx].dst : '0;
      wide_r    <= xfer && sts[gidx].wide;
      irq_r     <= irq_vec;
      err_r     <= tick && (|err_vec);
      en_any_r  <= |en_vec;
      run_any_r <= |busy_vec;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_xfer_valid   = xfer_r;
  assign out_xfer_channel = xch_r;
  assign out_src_addr     = src_r;
  assign out_dst_addr     = dst_r;
  assign out_wide         = wide_r;
  assign out_irq_bits     = irq_r;
  assign out_start_error  = err_r;
  assign out_any_enabled  = en_any_r;
  assign out_any_running  = run_any_r;

endmodule

@@ src/fcdma_chk.sv @@
// port-level checks for the four-channel dma controller, bound to the top level
module fcdma_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_xfer_valid,
  input logic [fcdma_pkg::CH_W-1:0]   out_xfer_channel,
  input logic [fcdma_pkg::ADDR_W-1:0] out_src_addr,
  input logic [fcdma_pkg::ADDR_W-1:0] out_dst_addr,
  input logic                         out_wide,
  input logic [fcdma_pkg::NUM_CH-1:0] out_irq_bits,
  input logic                         out_start_error,
  input logic                         out_any_enabled
);
  import fcdma_pkg::*;

  // a stalled result holds its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_addr)
      && $stable(out_dst_addr) && $stable(out_xfer_valid))
    else $error("stalled result changed");

  // results without a transfer carry zero transfer fields
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_xfer_valid |-> out_src_addr == '0 && out_dst_addr == '0
      && !out_wide && out_xfer_channel == '0)
    else $error("transfer fields set without transfer");

  // only the transferring channel can raise its interrupt
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_bits != '0 |-> out_xfer_valid && $onehot(out_irq_bits)
      && out_irq_bits[out_xfer_channel])
    else $error("interrupt without matching transfer");

  // a start error comes with at least one channel still enabled
  a_err_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_error |-> out_any_enabled)
    else $error("start error with no channel enabled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind four_channel_dma_controller fcdma_chk u_fcdma_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_xfer_valid   (out_xfer_valid),
  .out_xfer_channel (out_xfer_channel),
  .out_src_addr     (out_src_addr),
  .out_dst_addr     (out_dst_addr),
  .out_wide         (out_wide),
  .out_irq_bits     (out_irq_bits),
  .out_start_error  (out_start_error),
  .out_any_enabled  (out_any_enabled)
);
